[rtl/pia_pkg.sv]
// Package for the point-in-aperture shape test.
// Holds widths, codes and the structs passed between the pipeline modules.
// Depends on nothing.
package pia_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SIZE_WIDTH = 24;
	localparam int REG_INDEX_WIDTH = 2;

	// doubled coordinate, signed
	localparam int DBL_WIDTH = COORD_WIDTH + 1;
	// sums of a doubled coordinate and a size, signed
	localparam int SUM_WIDTH = ((DBL_WIDTH > SIZE_WIDTH + 1) ? DBL_WIDTH : SIZE_WIDTH + 1) + 1;
	localparam int MAG_WIDTH = (DBL_WIDTH > SIZE_WIDTH) ? DBL_WIDTH : SIZE_WIDTH;
	// trapezoid cross-product terms
	localparam int PROD_WIDTH = SUM_WIDTH + SIZE_WIDTH + 2;
	localparam int DIFF_WIDTH = PROD_WIDTH + 1;
	// ellipse products and their squares
	localparam int PP_WIDTH = 2 * SIZE_WIDTH;
	localparam int SQ_WIDTH = 4 * SIZE_WIDTH;

	typedef enum logic [1:0] {
		SHAPE_UNLIMITED = 2'd0,
		SHAPE_RECT      = 2'd1,
		SHAPE_TRAP      = 2'd2,
		SHAPE_ELLIPSE   = 2'd3
	} pia_shape_t;

	typedef enum logic [REG_INDEX_WIDTH-1:0] {
		REG_SHAPE_KIND = 2'd0,
		REG_SIZE_X     = 2'd1,
		REG_SIZE_Z     = 2'd2,
		REG_FAR_WIDTH  = 2'd3
	} pia_reg_t;

	typedef struct packed {
		pia_shape_t             kind;
		logic [SIZE_WIDTH-1:0]  size_x;
		logic [SIZE_WIDTH-1:0]  size_z;
		logic [SIZE_WIDTH-1:0]  far_width;
	} pia_cfg_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pia_adv_t;

	// first-stage word
	typedef struct packed {
		logic                         rect_in;
		logic                         trap_ok;
		logic                         ell_ok;
		logic signed [SUM_WIDTH-1:0]  xpa;
		logic signed [SUM_WIDTH-1:0]  xma;
		logic signed [SUM_WIDTH-1:0]  zpl;
		logic signed [SIZE_WIDTH:0]   amb;
		logic [SIZE_WIDTH-1:0]        ax;
		logic [SIZE_WIDTH-1:0]        az;
	} pia_s1_t;

endpackage

[rtl/pia_cfg.sv]
// Configuration registers of the point-in-aperture shape test.
// Depends on pia_pkg.
module pia_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pia_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [pia_pkg::SIZE_WIDTH-1:0]       cfg_data,
	output pia_pkg::pia_cfg_t                    cfg
);

	pia_pkg::pia_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (pia_pkg::pia_reg_t'(cfg_index))
				pia_pkg::REG_SHAPE_KIND: cfg_q.kind <= pia_pkg::pia_shape_t'(cfg_data[1:0]);
				pia_pkg::REG_SIZE_X:     cfg_q.size_x <= cfg_data;
				pia_pkg::REG_SIZE_Z:     cfg_q.size_z <= cfg_data;
				pia_pkg::REG_FAR_WIDTH:  cfg_q.far_width <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/pia_prep.sv]
// First pipeline stage: doubles the point, does the rectangle bounds,
// the trapezoid and ellipse range gates and the sums fed to the multipliers.
// Depends on pia_pkg.
module pia_prep (
	input  logic                                  clk,
	input  pia_pkg::pia_adv_t                     adv,
	input  pia_pkg::pia_cfg_t                     cfg,
	input  logic signed [pia_pkg::COORD_WIDTH-1:0] pos_x,
	input  logic signed [pia_pkg::COORD_WIDTH-1:0] pos_z,
	output pia_pkg::pia_s1_t                      s1
);

	localparam int DW = pia_pkg::DBL_WIDTH;
	localparam int SW = pia_pkg::SUM_WIDTH;
	localparam int MW = pia_pkg::MAG_WIDTH;
	localparam int ZW = pia_pkg::SIZE_WIDTH;

	logic signed [DW-1:0] xd, zd;
	logic [DW-1:0]        ax, az;
	logic signed [SW-1:0] xe, ze, wx, lz;
	pia_pkg::pia_s1_t     nxt;
	pia_pkg::pia_s1_t     word_s1;

	always_comb begin
		xd = $signed({pos_x, 1'b0});
		zd = $signed({pos_z, 1'b0});
		ax = xd[DW-1] ? (~xd + DW'(1)) : xd;
		az = zd[DW-1] ? (~zd + DW'(1)) : zd;
		xe = SW'(xd);
		ze = SW'(zd);
		wx = $signed(SW'(cfg.size_x));
		lz = $signed(SW'(cfg.size_z));

		nxt.rect_in = (xe > -wx) && (xe < wx) && (ze > -lz) && (ze < lz);
		nxt.trap_ok = (cfg.size_x != '0) && (cfg.far_width != '0)
			&& (ze > -lz) && (ze < lz);
		nxt.ell_ok  = (cfg.size_x != '0) && (cfg.size_z != '0)
			&& (MW'(ax) <= MW'(cfg.size_x)) && (MW'(az) <= MW'(cfg.size_z));
		nxt.xpa = xe + wx;
		nxt.xma = xe - wx;
		nxt.zpl = ze + lz;
		nxt.amb = $signed({1'b0, cfg.size_x}) - $signed({1'b0, cfg.far_width});
		// only meaningful once the gate has passed, then both fit the size width
		nxt.ax = ZW'(ax);
		nxt.az = ZW'(az);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			word_s1 <= nxt;
		end
	end

	assign s1 = word_s1;

endmodule

[rtl/pia_trap.sv]
// Trapezoid datapath, stages two to four: cross products, then their signs.
// Depends on pia_pkg.
module pia_trap (
	input  logic              clk,
	input  pia_pkg::pia_adv_t adv,
	input  pia_pkg::pia_cfg_t cfg,
	input  pia_pkg::pia_s1_t  s1,
	output logic              trap_in
);

	localparam int PW = pia_pkg::PROD_WIDTH;
	localparam int DFW = pia_pkg::DIFF_WIDTH;

	logic signed [pia_pkg::SIZE_WIDTH+1:0] twol;
	logic signed [PW-1:0]  m1_s2, m2_s2, m3_s2;
	logic                  ok_s2;
	logic signed [DFW-1:0] d3, d4;
	logic                  pos3, neg3, pos4, neg4;
	logic                  trap_in_s3, trap_in_s4;

	assign twol = $signed({1'b0, cfg.size_z, 1'b0});

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			m1_s2 <= PW'($signed(s1.xpa)) * PW'(twol);
			m2_s2 <= PW'($signed(s1.xma)) * PW'(twol);
			m3_s2 <= PW'($signed(s1.zpl)) * PW'($signed(s1.amb));
			ok_s2 <= s1.trap_ok;
		end
	end

	// left edge term minus, right edge term plus (b - a = -(a - b))
	always_comb begin
		d3 = DFW'(m1_s2) - DFW'(m3_s2);
		d4 = DFW'(m2_s2) + DFW'(m3_s2);
		neg3 = d3[DFW-1];
		pos3 = !d3[DFW-1] && (d3 != '0);
		neg4 = d4[DFW-1];
		pos4 = !d4[DFW-1] && (d4 != '0);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			trap_in_s3 <= ok_s2 && ((pos3 && neg4) || (neg3 && pos4));
		end
		if (adv.s4) begin
			trap_in_s4 <= trap_in_s3;
		end
	end

	assign trap_in = trap_in_s4;

endmodule

[rtl/pia_ellipse.sv]
// Ellipse datapath, stages two to four: (ax*dz)^2 + (az*dx)^2 against (dx*dz)^2,
// squares split into half-width partial products. Depends on pia_pkg.
module pia_ellipse (
	input  logic              clk,
	input  pia_pkg::pia_adv_t adv,
	input  pia_pkg::pia_cfg_t cfg,
	input  pia_pkg::pia_s1_t  s1,
	output logic              ell_in
);

	localparam int ZW = pia_pkg::SIZE_WIDTH;
	localparam int PPW = pia_pkg::PP_WIDTH;
	localparam int SQW = pia_pkg::SQ_WIDTH;

	// lanes: 0 = ax*dz, 1 = az*dx, 2 = dx*dz
	logic [PPW-1:0] p_s2 [3];
	logic           ok_s2, ok_s3, ok_s4;
	logic [PPW-1:0] hh_s3 [3];
	logic [PPW-1:0] hl_s3 [3];
	logic [PPW-1:0] ll_s3 [3];
	logic [SQW-1:0] sq_s4 [3];
	logic [SQW:0]   lhs;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p_s2[0] <= PPW'(s1.ax) * PPW'(cfg.size_z);
			p_s2[1] <= PPW'(s1.az) * PPW'(cfg.size_x);
			p_s2[2] <= PPW'(cfg.size_x) * PPW'(cfg.size_z);
			ok_s2   <= s1.ell_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int i = 0; i < 3; i++) begin
				hh_s3[i] <= PPW'(p_s2[i][PPW-1:ZW]) * PPW'(p_s2[i][PPW-1:ZW]);
				hl_s3[i] <= PPW'(p_s2[i][PPW-1:ZW]) * PPW'(p_s2[i][ZW-1:0]);
				ll_s3[i] <= PPW'(p_s2[i][ZW-1:0]) * PPW'(p_s2[i][ZW-1:0]);
			end
			ok_s3 <= ok_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (SQW'(hh_s3[i]) << (2 * ZW)) + (SQW'(hl_s3[i]) << (ZW + 1))
					+ SQW'(ll_s3[i]);
			end
			ok_s4 <= ok_s3;
		end
	end

	// boundary counts as inside
	always_comb begin
		lhs = (SQW+1)'(sq_s4[0]) + (SQW+1)'(sq_s4[1]);
		ell_in = ok_s4 && (lhs <= (SQW+1)'(sq_s4[2]));
	end

endmodule

[rtl/point_in_aperture_shape_test.sv]
// Point-in-aperture shape test: top level, pipeline control and result stage.
// Depends on pia_pkg, pia_cfg, pia_prep, pia_trap and pia_ellipse.
//
// Takes one point per clock while pt_stall is low and returns one inside/outside
// word per point, in order. Each point passes through five register stages:
// bounds and sums, the first multiply, the partial-product squares, their
// assembly, and the final compare and shape select. Stages move independently,
// so a stall on the result side fills bubbles before the point side is stalled.
// Shape registers may only be written with the pipeline empty.
module point_in_aperture_shape_test (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pt_valid,
	output logic                                  pt_stall,
	input  logic signed [pia_pkg::COORD_WIDTH-1:0] pos_x,
	input  logic signed [pia_pkg::COORD_WIDTH-1:0] pos_z,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic                                  inside_res,
	input  logic                                  cfg_wr_en,
	input  logic [pia_pkg::REG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [pia_pkg::SIZE_WIDTH-1:0]        cfg_data
);

	pia_pkg::pia_cfg_t cfg;
	pia_pkg::pia_adv_t adv;
	pia_pkg::pia_s1_t  s1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rect_s2, rect_s3, rect_s4;
	logic trap_in, ell_in;
	logic inside_s5;
	logic inside_nxt;

	pia_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pia_prep u_prep (
		.clk   (clk),
		.adv   (adv),
		.cfg   (cfg),
		.pos_x (pos_x),
		.pos_z (pos_z),
		.s1    (s1)
	);

	pia_trap u_trap (
		.clk     (clk),
		.adv     (adv),
		.cfg     (cfg),
		.s1      (s1),
		.trap_in (trap_in)
	);

	pia_ellipse u_ellipse (
		.clk    (clk),
		.adv    (adv),
		.cfg    (cfg),
		.s1     (s1),
		.ell_in (ell_in)
	);

	// a stage loads when it is empty or its word moves on
	always_comb begin
		adv.s5 = !v_s5 || !res_stall;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign pt_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= pt_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) rect_s2 <= s1.rect_in;
		if (adv.s3) rect_s3 <= rect_s2;
		if (adv.s4) rect_s4 <= rect_s3;
	end

	always_comb begin
		case (cfg.kind)
			pia_pkg::SHAPE_UNLIMITED: inside_nxt = 1'b1;
			pia_pkg::SHAPE_RECT:      inside_nxt = rect_s4;
			pia_pkg::SHAPE_TRAP:      inside_nxt = trap_in;
			pia_pkg::SHAPE_ELLIPSE:   inside_nxt = ell_in;
			default:                  inside_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			inside_s5 <= inside_nxt;
		end
	end

	assign res_valid  = v_s5;
	assign inside_res = inside_s5;

`ifndef SYNTH
	// an accepted word lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall |=> v_s1)
		else $error("accepted point missing from first stage");

	// the point side only stalls when every stage holds a word
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("point side stalled with a bubble in the pipeline");

	// a blocked stage keeps its word
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !adv.s5 |=> v_s4)
		else $error("stage four word lost under stall");

	// unlimited aperture never reports outside
	a_unlimited: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (cfg.kind == pia_pkg::SHAPE_UNLIMITED) |-> inside_res)
		else $error("unlimited shape reported outside");
`endif

endmodule

[verif/point_in_aperture_shape_test_tb.sv]
// Self-checking testbench for point_in_aperture_shape_test.
// Predicts the inside/outside word for every accepted point and checks it in order.
// Depends on pia_pkg and the point_in_aperture_shape_test RTL.
module point_in_aperture_shape_test_tb;

	typedef logic signed [pia_pkg::COORD_WIDTH-1:0] coord_t;
	typedef logic [pia_pkg::SIZE_WIDTH-1:0] size_t;

	localparam longint COORD_MAX = (longint'(1) << (pia_pkg::COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) << (pia_pkg::COORD_WIDTH - 1));
	localparam size_t SIZE_MAX = '1;
	localparam int RANDOM_POINTS = 1750;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT = 5000;

	// holds its own copy of the shape registers and the words still owed
	class aperture_scoreboard;
		pia_pkg::pia_shape_t kind = pia_pkg::SHAPE_UNLIMITED;
		size_t size_x = '0;
		size_t size_z = '0;
		size_t far_width = '0;
		bit inside_q[$];
		int unsigned fault_count = 0;

		function void set_reg(pia_pkg::pia_reg_t idx, size_t val);
			case (idx)
				pia_pkg::REG_SHAPE_KIND: kind = pia_pkg::pia_shape_t'(val[1:0]);
				pia_pkg::REG_SIZE_X:     size_x = val;
				pia_pkg::REG_SIZE_Z:     size_z = val;
				pia_pkg::REG_FAR_WIDTH:  far_width = val;
				default: ;
			endcase
		endfunction

		// works on doubled coordinates so half sizes stay whole
		function bit point_inside(coord_t px, coord_t pz);
			longint xx, zz, a, b, l, s3, s4;
			logic [127:0] ax, az, dx, dz, lhs, rhs;
			xx = 2 * longint'(px);
			zz = 2 * longint'(pz);
			a = longint'(size_x);
			b = longint'(far_width);
			l = longint'(size_z);
			case (kind)
				pia_pkg::SHAPE_UNLIMITED: return 1'b1;
				pia_pkg::SHAPE_RECT: return xx > -a && xx < a && zz > -l && zz < l;
				pia_pkg::SHAPE_TRAP: begin
					if (a == 0 || b == 0 || zz <= -l || zz >= l)
						return 1'b0;
					// signs against the two slanted sides; zero means on the side
					s3 = (xx + a) * (2 * l) - (zz + l) * (a - b);
					s4 = (xx - a) * (2 * l) - (zz + l) * (b - a);
					return (s3 > 0 && s4 < 0) || (s3 < 0 && s4 > 0);
				end
				default: begin
					dx = size_x;
					dz = size_z;
					ax = (xx < 0) ? -xx : xx;
					az = (zz < 0) ? -zz : zz;
					if (dx == 0 || dz == 0 || ax > dx || az > dz)
						return 1'b0;
					lhs = ax * ax * dz * dz + az * az * dx * dx;
					rhs = dx * dx * dz * dz;
					return lhs <= rhs;
				end
			endcase
		endfunction

		function void note_point(coord_t px, coord_t pz);
			inside_q.push_back(point_inside(px, pz));
		endfunction

		function void check_inside(logic got);
			bit want;
			if (inside_q.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: result word %b with no point outstanding", $realtime, got);
				return;
			end
			want = inside_q.pop_front();
			if (got !== want) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: inside_res expected %b got %b", $realtime, want, got);
			end
		endfunction

		function int pending();
			return inside_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	coord_t pos_x = '0;
	coord_t pos_z = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic inside_res;
	logic cfg_wr_en = 1'b0;
	logic [pia_pkg::REG_INDEX_WIDTH-1:0] cfg_index = '0;
	size_t cfg_data = '0;

	aperture_scoreboard sb = new();
	bit no_gaps = 1'b0;
	int unsigned idle_cycles = 0;

	point_in_aperture_shape_test dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.pos_x      (pos_x),
		.pos_z      (pos_z),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.inside_res (inside_res),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	// somewhere in a box just larger than the shape
	function automatic coord_t near_coord(longint half);
		longint span;
		span = half + 2;
		return clamp_coord(longint'($urandom_range(0, 2 * span)) - span);
	endfunction

	// on or one unit either side of a boundary
	function automatic coord_t rim_coord(longint half);
		longint v;
		v = $urandom_range(0, 1) ? half : -half;
		return clamp_coord(v + longint'($urandom_range(0, 2)) - 1);
	endfunction

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'(COORD_MIN);
			1: return coord_t'(COORD_MAX);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic size_t pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return SIZE_MAX;
		if (r < 30)
			return pia_pkg::SIZE_WIDTH'(1);
		if (r < 70)
			return pia_pkg::SIZE_WIDTH'($urandom_range(2, 64));
		return pia_pkg::SIZE_WIDTH'($urandom_range(0, SIZE_MAX));
	endfunction

	task automatic write_reg(pia_pkg::pia_reg_t idx, size_t val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic apply_shape(pia_pkg::pia_shape_t kind, size_t sx, size_t sz, size_t fw);
		write_reg(pia_pkg::REG_SHAPE_KIND, pia_pkg::SIZE_WIDTH'(kind));
		write_reg(pia_pkg::REG_SIZE_X, sx);
		write_reg(pia_pkg::REG_SIZE_Z, sz);
		write_reg(pia_pkg::REG_FAR_WIDTH, fw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// returns in the step of the accepting edge
	task automatic send_point(coord_t px, coord_t pz);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pos_x <= px;
		pos_z <= pz;
		do
			@(posedge clk);
		while (pt_stall);
		sb.note_point(px, pz);
	endtask

	task automatic drain_pipe();
		pt_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int n);
		longint hx, hz;
		int unsigned r;
		coord_t px, pz;
		hx = longint'((sb.size_x > sb.far_width) ? sb.size_x : sb.far_width) / 2;
		hz = longint'(sb.size_z) / 2;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				px = near_coord(hx);
				pz = near_coord(hz);
			end else if (r < 70) begin
				if ($urandom_range(0, 1)) begin
					px = rim_coord(hx);
					pz = near_coord(hz);
				end else begin
					px = near_coord(hx);
					pz = rim_coord(hz);
				end
			end else if (r < 92) begin
				px = coord_t'($urandom);
				pz = coord_t'($urandom);
			end else begin
				px = extreme_coord();
				pz = extreme_coord();
			end
			send_point(px, pz);
		end
	endtask

	// result side: stall-free runs, occasionally long, between mostly short stalls
	initial begin : result_stall_gen
		int unsigned run_len, hold_len;
		forever begin
			run_len = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
			res_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			hold_len = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 4)
				: $urandom_range(20, 60);
			res_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_inside(inside_res);
	end

	always @(posedge clk) begin
		if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("point_in_aperture_shape_test_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers as left by reset: unlimited, everything inside
		send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN));
		send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX));
		send_point(0, 0);
		drain_pipe();

		// rectangle: bounds are strict
		apply_shape(pia_pkg::SHAPE_RECT, 10, 6, 0);
		send_point(4, 2);
		send_point(5, 0);
		send_point(-5, 0);
		send_point(0, 3);
		send_point(-4, -2);
		drain_pipe();
		apply_shape(pia_pkg::SHAPE_RECT, 0, 6, 0);
		send_point(0, 0);
		drain_pipe();

		// trapezoid with near width 8, far width 4, length 6; sides are outside
		apply_shape(pia_pkg::SHAPE_TRAP, 8, 6, 4);
		send_point(3, 0);
		send_point(2, 0);
		send_point(-3, 0);
		send_point(0, -3);
		send_point(0, -2);
		drain_pipe();
		apply_shape(pia_pkg::SHAPE_TRAP, 8, 6, 0);
		send_point(0, 0);
		drain_pipe();

		// ellipse: the boundary counts as inside
		apply_shape(pia_pkg::SHAPE_ELLIPSE, 10, 6, 0);
		send_point(5, 0);
		send_point(0, 3);
		send_point(0, -3);
		send_point(5, 1);
		send_point(-6, 0);
		drain_pipe();
		apply_shape(pia_pkg::SHAPE_ELLIPSE, 10, 0, 0);
		send_point(0, 0);
		drain_pipe();
		apply_shape(pia_pkg::SHAPE_ELLIPSE, SIZE_MAX, SIZE_MAX, SIZE_MAX);
		send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN));
		send_point(coord_t'(COORD_MAX), 0);
		drain_pipe();

		sent = 0;
		while (sent < RANDOM_POINTS) begin
			apply_shape(pia_pkg::pia_shape_t'($urandom_range(0, 3)), pick_size(),
				pick_size(), pick_size());
			no_gaps = ($urandom_range(0, 4) == 0);
			n = $urandom_range(40, 100);
			run_phase(n);
			sent += n;
			drain_pipe();
		end

		if (sb.fault_count == 0)
			$display("point_in_aperture_shape_test_tb: done, clean");
		else
			$display("point_in_aperture_shape_test_tb: done, errors");
		$finish;
	end
endmodule
